// ----- hdl/rsmp_pkg.sv -----
package rsmp_pkg;

   localparam int COORD_W = 32;
   localparam int STEP_W  = 23;
   localparam int LEN_W   = 36;
   localparam int SQ_W    = 66;
   localparam int RAD_W   = 72;
   localparam int SQREM_W = 40;
   localparam int CW      = 37;   // running distance along a segment
   localparam int RW      = 38;   // divider partial remainder
   localparam int ITER_W  = 6;
   localparam logic [STEP_W-1:0] STEP_RESET = 23'd6554;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] ah;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] bh;
      logic                      is_start;
      logic                      emit_first;
      logic                      last;
   } seg_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_SQRT,
      ST_CHECK,
      ST_FIRST,
      ST_LOOP,
      ST_DIV,
      ST_MUL,
      ST_SAMPLE,
      ST_MOD,
      ST_FIX,
      ST_FINAL
   } back_state_type;

endpackage

// ----- hdl/rsmp_front.sv -----
module rsmp_front
   import rsmp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_x_in,
   input  logic signed [COORD_W-1:0] req_y_in,
   input  logic signed [COORD_W-1:0] req_heading_in,
   input  logic                      req_path_start,
   input  logic                      req_path_last,
   input  logic                      fifo_full,
   output logic                      fifo_push,
   output seg_entry_type             fifo_wdata
);

   logic                      have_prev_ff, have_prev_in;
   logic                      first_done_ff, first_done_in;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff, prev_h_ff;
   logic                      is_start;

   assign req_stall = fifo_full;
   assign fifo_push = req_valid && !fifo_full;
   assign is_start  = req_path_start || !have_prev_ff;

   always_comb begin
      fifo_wdata.ax         = prev_x_ff;
      fifo_wdata.ay         = prev_y_ff;
      fifo_wdata.ah         = prev_h_ff;
      fifo_wdata.bx         = req_x_in;
      fifo_wdata.by         = req_y_in;
      fifo_wdata.bh         = req_heading_in;
      fifo_wdata.is_start   = is_start;
      fifo_wdata.emit_first = !first_done_ff;
      fifo_wdata.last       = req_path_last;
   end

   // path bookkeeping on each push follows the start and last marks and whether a previous point is held
   always_comb begin
      have_prev_in  = have_prev_ff;
      first_done_in = first_done_ff;
      if (fifo_push) begin
         if (is_start) begin
            have_prev_in  = !req_path_last;
            first_done_in = 1'b0;
         end else if (req_path_last) begin
            have_prev_in  = 1'b0;
            first_done_in = 1'b0;
         end else begin
            first_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         first_done_ff <= 1'b0;
      end else begin
         have_prev_ff  <= have_prev_in;
         first_done_ff <= first_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         prev_x_ff <= req_x_in;
         prev_y_ff <= req_y_in;
         prev_h_ff <= req_heading_in;
      end
   end

endmodule

// ----- hdl/rsmp_fifo.sv -----
module rsmp_fifo
   import rsmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  seg_entry_type wdata,
   output logic          full,
   input  logic          pop,
   output seg_entry_type rdata,
   output logic          empty
);

   seg_entry_type mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- hdl/rsmp_back.sv -----
module rsmp_back
   import rsmp_pkg::*;
#(
   parameter int MAX_SAMPLES_PER_SEGMENT = 62,
   parameter int FRACTION_BITS           = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [STEP_W-1:0]         csr_wdata,
   input  logic                      fifo_empty,
   input  seg_entry_type             fifo_rdata,
   output logic                      fifo_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_x_out,
   output logic signed [COORD_W-1:0] rsp_y_out,
   output logic signed [COORD_W-1:0] rsp_heading_out,
   output logic                      rsp_run_last,
   output logic                      rsp_path_end,
   output logic                      rsp_truncated
);

   localparam int SCW = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
   localparam int PW  = COORD_W + 1 + FRACTION_BITS + 1;

   back_state_type state_ff, state_in;

   logic [STEP_W-1:0]  step_ff, step_in, step_eff;
   logic [STEP_W-1:0]  carried_ff, carried_in;
   seg_entry_type      ent_ff, ent_in;
   logic [SQ_W-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [SQREM_W-1:0] sq_rem_ff, sq_rem_in;
   logic [LEN_W-1:0]   root_ff, root_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [CW-1:0]      c_ff, c_in;
   logic [SCW-1:0]     scnt_ff, scnt_in;
   logic               trunc_ff, trunc_in;
   logic [RW-1:0]      div_rem_ff, div_rem_in;
   logic [CW-1:0]      div_sh_ff, div_sh_in;
   logic signed [PW-1:0] prod_ff [3];
   logic signed [PW-1:0] prod_in [3];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_h_ff;
   logic signed [COORD_W-1:0] rsp_x_in, rsp_y_in, rsp_h_in;
   logic                      rsp_run_last_ff, rsp_run_last_in;
   logic                      rsp_path_end_ff, rsp_path_end_in;
   logic                      rsp_trunc_ff, rsp_trunc_in;

   // combinational helpers
   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W:0]        adx, ady;
   logic [SQREM_W-1:0]      sq_rem_sh, sq_trial;
   logic [RW-1:0]           div_rem_sh, divisor;
   logic [CW-1:0]           span, c_len, c_next;
   logic                    out_free, emit, more_samples, next_more;
   logic [FRACTION_BITS-1:0] t_frac;
   logic signed [COORD_W:0] lane_d [3];
   logic signed [PW-1:0]    lane_q [3];
   logic [COORD_W-1:0]      lane_r [3];
   logic signed [COORD_W-1:0] lane_a [3];
   logic signed [COORD_W-1:0] lane_b [3];

   assign step_eff     = (step_ff == '0) ? STEP_W'(1) : step_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign c_len        = {1'b0, root_ff};
   assign c_next       = c_ff + CW'(step_eff);
   assign span         = CW'(MAX_SAMPLES_PER_SEGMENT) * CW'(step_eff);
   assign more_samples = (c_ff < c_len) && (scnt_ff < SCW'(MAX_SAMPLES_PER_SEGMENT));
   assign next_more    = (c_next < c_len) && ((scnt_ff + SCW'(1)) < SCW'(MAX_SAMPLES_PER_SEGMENT));
   assign fifo_pop     = (state_ff == ST_IDLE) && !fifo_empty;
   assign t_frac       = div_sh_ff[FRACTION_BITS-1:0];

   assign dx  = {ent_ff.bx[COORD_W-1], ent_ff.bx} - {ent_ff.ax[COORD_W-1], ent_ff.ax};
   assign dy  = {ent_ff.by[COORD_W-1], ent_ff.by} - {ent_ff.ay[COORD_W-1], ent_ff.ay};
   assign adx = dx[COORD_W] ? -dx : dx;
   assign ady = dy[COORD_W] ? -dy : dy;

   // one bit of the root per cycle
   assign sq_rem_sh = {sq_rem_ff[SQREM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign sq_trial  = {2'b00, root_ff, 2'b01};

   // shared restoring divider: fraction c/len or remainder modulo the step
   assign divisor    = (state_ff == ST_DIV) ? RW'(root_ff) : RW'(step_eff);
   assign div_rem_sh = {div_rem_ff[RW-2:0], div_sh_ff[CW-1]};

   assign lane_a[0] = ent_ff.ax;
   assign lane_a[1] = ent_ff.ay;
   assign lane_a[2] = ent_ff.ah;
   assign lane_b[0] = ent_ff.bx;
   assign lane_b[1] = ent_ff.by;
   assign lane_b[2] = ent_ff.bh;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lane_d[i]  = {lane_b[i][COORD_W-1], lane_b[i]} - {lane_a[i][COORD_W-1], lane_a[i]};
         prod_in[i] = PW'(lane_d[i]) * PW'($signed({1'b0, t_frac}));
         // round half up, then add the offset to the start point
         lane_q[i]  = (prod_ff[i] + (PW'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
         lane_r[i]  = lane_a[i] + lane_q[i][COORD_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty && !fifo_rdata.is_start) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_SQRT;
         ST_SQRT: begin
            if (iter_ff == ITER_W'(LEN_W - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:  state_in = ent_ff.emit_first ? ST_FIRST : ST_LOOP;
         ST_FIRST: begin
            if (out_free) begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (more_samples) begin
               state_in = ST_DIV;
            end else if (c_ff < c_len) begin
               state_in = ST_MOD;
            end else begin
               state_in = ent_ff.last ? ST_FINAL : ST_IDLE;
            end
         end
         ST_DIV: begin
            if (iter_ff == ITER_W'(FRACTION_BITS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:    state_in = ST_SAMPLE;
         ST_SAMPLE: begin
            if (out_free) begin
               state_in = ST_LOOP;
            end
         end
         ST_MOD: begin
            if (iter_ff == ITER_W'(CW - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX:    state_in = ent_ff.last ? ST_FINAL : ST_IDLE;
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      step_in         = csr_write ? csr_wdata : step_ff;
      carried_in      = carried_ff;
      ent_in          = ent_ff;
      sqx_in          = sqx_ff;
      sqy_in          = sqy_ff;
      rad_in          = rad_ff;
      sq_rem_in       = sq_rem_ff;
      root_in         = root_ff;
      iter_in         = iter_ff;
      c_in            = c_ff;
      scnt_in         = scnt_ff;
      trunc_in        = trunc_ff;
      div_rem_in      = div_rem_ff;
      div_sh_in       = div_sh_ff;
      emit            = 1'b0;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;
      rsp_h_in        = rsp_h_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_path_end_in = rsp_path_end_ff;
      rsp_trunc_in    = rsp_trunc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (fifo_pop) begin
               ent_in = fifo_rdata;
               if (fifo_rdata.is_start) begin
                  carried_in = step_eff;
               end
            end
         end
         ST_SQUARE: begin
            sqx_in = SQ_W'(adx) * SQ_W'(adx);
            sqy_in = SQ_W'(ady) * SQ_W'(ady);
         end
         ST_SUM: begin
            rad_in    = RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
            sq_rem_in = '0;
            root_in   = '0;
            iter_in   = '0;
         end
         ST_SQRT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            iter_in = iter_ff + ITER_W'(1);
            if (sq_rem_sh >= sq_trial) begin
               sq_rem_in = sq_rem_sh - sq_trial;
               root_in   = {root_ff[LEN_W-2:0], 1'b1};
            end else begin
               sq_rem_in = sq_rem_sh;
               root_in   = {root_ff[LEN_W-2:0], 1'b0};
            end
         end
         ST_CHECK: begin
            c_in     = CW'(carried_ff);
            scnt_in  = '0;
            trunc_in = (CW'(carried_ff) + span) < c_len;
         end
         ST_FIRST: begin
            emit            = 1'b1;
            rsp_x_in        = ent_ff.ax;
            rsp_y_in        = ent_ff.ay;
            rsp_h_in        = ent_ff.ah;
            rsp_run_last_in = !(ent_ff.last || (c_ff < c_len));
            rsp_path_end_in = 1'b0;
            rsp_trunc_in    = trunc_ff;
         end
         ST_LOOP: begin
            iter_in = '0;
            if (more_samples) begin
               div_rem_in = RW'(c_ff);
               div_sh_in  = '0;
            end else if (c_ff < c_len) begin
               div_rem_in = '0;
               div_sh_in  = c_len - c_ff;
            end else begin
               carried_in = STEP_W'(c_ff - c_len);
            end
         end
         ST_DIV, ST_MOD: begin
            iter_in = iter_ff + ITER_W'(1);
            if (div_rem_sh >= divisor) begin
               div_rem_in = div_rem_sh - divisor;
               div_sh_in  = {div_sh_ff[CW-2:0], 1'b1};
            end else begin
               div_rem_in = div_rem_sh;
               div_sh_in  = {div_sh_ff[CW-2:0], 1'b0};
            end
         end
         ST_SAMPLE: begin
            emit            = 1'b1;
            rsp_x_in        = lane_r[0];
            rsp_y_in        = lane_r[1];
            rsp_h_in        = lane_r[2];
            rsp_run_last_in = !(ent_ff.last || next_more);
            rsp_path_end_in = 1'b0;
            rsp_trunc_in    = trunc_ff;
            if (out_free) begin
               c_in    = c_next;
               scnt_in = scnt_ff + SCW'(1);
            end
         end
         ST_FIX: begin
            // distance overshoot past the segment end after the dropped samples
            if (div_rem_ff[STEP_W-1:0] == '0) begin
               carried_in = '0;
            end else begin
               carried_in = step_eff - div_rem_ff[STEP_W-1:0];
            end
         end
         ST_FINAL: begin
            emit            = 1'b1;
            rsp_x_in        = ent_ff.bx;
            rsp_y_in        = ent_ff.by;
            rsp_h_in        = ent_ff.bh;
            rsp_run_last_in = 1'b1;
            rsp_path_end_in = 1'b1;
            rsp_trunc_in    = trunc_ff;
         end
         default: begin
         end
      endcase

      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      if (!(emit && out_free)) begin
         rsp_x_in        = rsp_x_ff;
         rsp_y_in        = rsp_y_ff;
         rsp_h_in        = rsp_h_ff;
         rsp_run_last_in = rsp_run_last_ff;
         rsp_path_end_in = rsp_path_end_ff;
         rsp_trunc_in    = rsp_trunc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_RESET;
         carried_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         carried_ff   <= carried_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff          <= ent_in;
      sqx_ff          <= sqx_in;
      sqy_ff          <= sqy_in;
      rad_ff          <= rad_in;
      sq_rem_ff       <= sq_rem_in;
      root_ff         <= root_in;
      iter_ff         <= iter_in;
      c_ff            <= c_in;
      scnt_ff         <= scnt_in;
      trunc_ff        <= trunc_in;
      div_rem_ff      <= div_rem_in;
      div_sh_ff       <= div_sh_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_h_ff        <= rsp_h_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_path_end_ff <= rsp_path_end_in;
      rsp_trunc_ff    <= rsp_trunc_in;
      if (state_ff == ST_MUL) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_out       = rsp_x_ff;
   assign rsp_y_out       = rsp_y_ff;
   assign rsp_heading_out = rsp_h_ff;
   assign rsp_run_last    = rsp_run_last_ff;
   assign rsp_path_end    = rsp_path_end_ff;
   assign rsp_truncated   = rsp_trunc_ff;

endmodule

// ----- hdl/polyline_arc_length_resampler.sv -----
// Resamples a waypoint path (x, y, heading in signed Q16.16) at a fixed arc-length step
// set by csr_wdata (reset 0.1 m, zero acts as one LSB). The front end takes one
// waypoint transaction per cycle into a two-entry queue while it is not full; the back
// end then works each segment through a bit-serial square root, and per interpolated
// pose a restoring divider of FRACTION_BITS quotient bits plus a multiply and an output
// step. A remainder pass through the same divider follows when the sample cap cuts
// the segment short; a path-start waypoint only resets the carried distance. The
// output register lets the back end move on while a pose waits on rsp_stall, until
// it has its next pose to emit.
module polyline_arc_length_resampler
   import rsmp_pkg::*;
#(
   parameter int MAX_SAMPLES_PER_SEGMENT = 62,
   parameter int FRACTION_BITS           = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // waypoint transactions
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_x_in,
   input  logic signed [COORD_W-1:0] req_y_in,
   input  logic signed [COORD_W-1:0] req_heading_in,
   input  logic                      req_path_start,
   input  logic                      req_path_last,
   // resampled pose transactions
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_x_out,
   output logic signed [COORD_W-1:0] rsp_y_out,
   output logic signed [COORD_W-1:0] rsp_heading_out,
   output logic                      rsp_run_last,
   output logic                      rsp_path_end,
   output logic                      rsp_truncated,
   // step length register
   input  logic                      csr_write,
   input  logic [STEP_W-1:0]         csr_wdata
);

   logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
   seg_entry_type fifo_wdata, fifo_rdata;

   // classifies each waypoint as path start or segment end
   rsmp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_in       (req_x_in),
      .req_y_in       (req_y_in),
      .req_heading_in (req_heading_in),
      .req_path_start (req_path_start),
      .req_path_last  (req_path_last),
      .fifo_full      (fifo_full),
      .fifo_push      (fifo_push),
      .fifo_wdata     (fifo_wdata)
   );

   rsmp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fifo_push),
      .wdata (fifo_wdata),
      .full  (fifo_full),
      .pop   (fifo_pop),
      .rdata (fifo_rdata),
      .empty (fifo_empty)
   );

   // segment length, interpolation and carried distance
   rsmp_back #(
      .MAX_SAMPLES_PER_SEGMENT (MAX_SAMPLES_PER_SEGMENT),
      .FRACTION_BITS           (FRACTION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_wdata       (csr_wdata),
      .fifo_empty      (fifo_empty),
      .fifo_rdata      (fifo_rdata),
      .fifo_pop        (fifo_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_heading_out (rsp_heading_out),
      .rsp_run_last    (rsp_run_last),
      .rsp_path_end    (rsp_path_end),
      .rsp_truncated   (rsp_truncated)
   );

endmodule

// ----- dv/resample_checker.sv -----
`timescale 1ns / 100ps

module resample_checker
   import rsmp_pkg::*;
#(
   parameter int MAX_SAMPLES_PER_SEGMENT = 62,
   parameter int FRACTION_BITS           = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_x_in,
   input  logic signed [COORD_W-1:0] req_y_in,
   input  logic signed [COORD_W-1:0] req_heading_in,
   input  logic                      req_path_start,
   input  logic                      req_path_last,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [COORD_W-1:0] rsp_x_out,
   input  logic signed [COORD_W-1:0] rsp_y_out,
   input  logic signed [COORD_W-1:0] rsp_heading_out,
   input  logic                      rsp_run_last,
   input  logic                      rsp_path_end,
   input  logic                      rsp_truncated,
   input  logic                      csr_write,
   input  logic [STEP_W-1:0]         csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] h;
      logic               run_last;
      logic               path_end;
      logic               truncated;
   } pose_type;

   pose_type           expected_poses[$];
   logic [STEP_W-1:0]  step_reg;
   logic [COORD_W-1:0] prev_x, prev_y, prev_h;
   logic [31:0]        carry_dist;
   bit                 have_prev, first_done;

   function automatic logic [LEN_W-1:0] seg_len(longint dx, longint dy);
      longint unsigned    ax, ay;
      logic [SQ_W-1:0]    sq;
      logic [LEN_W-1:0]   root, cand;
      logic [RAD_W-1:0]   c2;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sq = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
      root = '0;
      for (int b = LEN_W - 1; b >= 0; b--) begin
         cand = root | (LEN_W'(1) << b);
         c2 = RAD_W'(cand) * RAD_W'(cand);
         if (c2 <= RAD_W'(sq)) root = cand;
      end
      return root;
   endfunction

   // rounded half up, no angle wrap
   function automatic logic [COORD_W-1:0] interp(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                                 longint t);
      longint d, q;
      d = (longint'($signed(b)) - longint'($signed(a))) * t;
      q = (d + (longint'(1) << (FRACTION_BITS - 1))) >>> FRACTION_BITS;
      return COORD_W'(longint'($signed(a)) + q);
   endfunction

   task automatic predict_poses(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [COORD_W-1:0] h, bit start, bit last);
      longint unsigned stp, len, c, t;
      int              cnt;
      bit              trunc;
      pose_type        run[$];
      pose_type        p;
      stp = (step_reg == 0) ? 1 : step_reg;
      trunc = 0;
      if (start || !have_prev) begin
         prev_x = x; prev_y = y; prev_h = h;
         carry_dist = 32'(stp);
         first_done = 0;
         have_prev = !last;
         return;
      end
      p = '{prev_x, prev_y, prev_h, 1'b0, 1'b0, 1'b0};
      if (!first_done) begin
         run = {run, p};
         first_done = 1;
      end
      len = seg_len(longint'($signed(x)) - longint'($signed(prev_x)),
                    longint'($signed(y)) - longint'($signed(prev_y)));
      c = carry_dist;
      cnt = 0;
      while (c < len && cnt < MAX_SAMPLES_PER_SEGMENT) begin
         t = (c << FRACTION_BITS) / len;
         p = '{interp(prev_x, x, t), interp(prev_y, y, t), interp(prev_h, h, t),
               1'b0, 1'b0, 1'b0};
         run = {run, p};
         c += stp;
         cnt++;
      end
      // dropped samples still advance the distance
      if (c < len) begin
         trunc = 1;
         c += ((len - c + stp - 1) / stp) * stp;
      end
      carry_dist = 32'(c - len);
      if (last) begin
         p = '{x, y, h, 1'b0, 1'b1, 1'b0};
         run = {run, p};
         have_prev = 0;
         first_done = 0;
      end else begin
         prev_x = x; prev_y = y; prev_h = h;
      end
      foreach (run[i]) run[i].truncated = trunc;
      if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
      expected_poses = {expected_poses, run};
   endtask

   always @(posedge clock) begin
      pose_type e;
      if (reset) begin
         step_reg = STEP_RESET;
         prev_x = '0; prev_y = '0; prev_h = '0;
         carry_dist = '0;
         have_prev = 0;
         first_done = 0;
         expected_poses.delete();
         fail_count = 0;
      end else begin
         if (csr_write) step_reg = csr_wdata;
         if (req_valid && !req_stall)
            predict_poses(req_x_in, req_y_in, req_heading_in, req_path_start, req_path_last);
         if (rsp_valid && !rsp_stall) begin
            if (expected_poses.size() == 0) begin
               $error("pose transaction with nothing expected");
               fail_count++;
            end else begin
               e = expected_poses.pop_front();
               if (rsp_x_out !== e.x) begin
                  $error("x_out expected %0d actual %0d", $signed(e.x), rsp_x_out);
                  fail_count++;
               end
               if (rsp_y_out !== e.y) begin
                  $error("y_out expected %0d actual %0d", $signed(e.y), rsp_y_out);
                  fail_count++;
               end
               if (rsp_heading_out !== e.h) begin
                  $error("heading_out expected %0d actual %0d", $signed(e.h), rsp_heading_out);
                  fail_count++;
               end
               if (rsp_run_last !== e.run_last) begin
                  $error("run_last expected %0d actual %0d", e.run_last, rsp_run_last);
                  fail_count++;
               end
               if (rsp_path_end !== e.path_end) begin
                  $error("path_end expected %0d actual %0d", e.path_end, rsp_path_end);
                  fail_count++;
               end
               if (rsp_truncated !== e.truncated) begin
                  $error("truncated expected %0d actual %0d", e.truncated, rsp_truncated);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_poses.size();
   end

endmodule

// ----- dv/tb_polyline_arc_length_resampler.sv -----
`timescale 1ns / 100ps

module tb_polyline_arc_length_resampler;
   import rsmp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;   // idle cycles
   localparam int SETTLE_CYCLES  = 300;     // covers queued waypoints that emit nothing
   localparam int HOLD_CYCLES    = 600;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_valid = 0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_x_in = '0;
   logic signed [COORD_W-1:0] req_y_in = '0;
   logic signed [COORD_W-1:0] req_heading_in = '0;
   logic                      req_path_start = 0;
   logic                      req_path_last = 0;
   logic                      rsp_valid;
   logic                      rsp_stall = 0;
   logic signed [COORD_W-1:0] rsp_x_out, rsp_y_out, rsp_heading_out;
   logic                      rsp_run_last, rsp_path_end, rsp_truncated;
   logic                      csr_write = 0;
   logic [STEP_W-1:0]         csr_wdata = '0;

   int  fail_count, pending;
   int  items_sent = 0;
   int  idle_cycles = 0;
   bit  hold_request = 0;
   longint unsigned cur_step = STEP_RESET;   // zero step acts as one

   always #4 clock = ~clock;

   polyline_arc_length_resampler dut (.*);

   resample_checker checker_i (.*);

   // watchdog: cycles with no transaction on any port
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int r, n;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 0;
            hold_request = 0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall = 0;
               n = $urandom_range(1, 20);
            end else if (r < 95) begin
               rsp_stall = 1;
               n = $urandom_range(1, 3);
            end else begin
               rsp_stall = 1;
               n = $urandom_range(20, 80);
            end
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // one waypoint transaction, then maybe a gap
   task automatic send_waypoint(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [COORD_W-1:0] h, bit start, bit last);
      int r, gap;
      @(negedge clock);
      req_valid = 1;
      req_x_in = x;
      req_y_in = y;
      req_heading_in = h;
      req_path_start = start;
      req_path_last = last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      r = $urandom_range(0, 99);
      gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // wait until all poses are in and the back end has drained, then write the step
   task automatic write_step(logic [STEP_W-1:0] value);
      @(negedge clock);
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write = 1;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 0;
      cur_step = (value == 0) ? 1 : value;
   endtask

   // segment offset of a few steps, sometimes zero
   function automatic logic [COORD_W-1:0] step_offset();
      longint d;
      if ($urandom_range(0, 9) == 0) return '0;
      d = longint'(cur_step) * $urandom_range(0, 6) + $urandom_range(0, 32'(cur_step));
      if ($urandom_range(0, 1)) d = -d;
      return COORD_W'(d);
   endfunction

   task automatic send_path(int npts, bit terminated);
      logic [COORD_W-1:0] x, y, h;
      x = $urandom;
      y = $urandom;
      h = $urandom;
      for (int i = 0; i < npts; i++) begin
         send_waypoint(x, y, h, i == 0, terminated && (i == npts - 1));
         x = x + step_offset();
         y = y + step_offset();
         h = ($urandom_range(0, 3) == 0) ? $urandom : h + step_offset();
      end
   endtask

   task automatic random_phase(int count, bit with_hold);
      int r, target;
      target = items_sent + count;
      while (items_sent < target) begin
         if (with_hold && !hold_request && items_sent > target - count / 2) begin
            hold_request = 1;
            with_hold = 0;
         end
         r = $urandom_range(0, 99);
         if (r < 70)
            send_path($urandom_range(2, 8), 1);
         else if (r < 85)
            send_path($urandom_range(1, 5), 0);   // left open, next start drops it
         else
            send_waypoint($urandom, $urandom, $urandom, $urandom_range(0, 1),
                          $urandom_range(0, 1));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // one-waypoint path emits nothing
      send_waypoint(32'd100, 32'd200, 32'd300, 1, 1);
      // plain path at the default step, with a zero-length segment inside
      send_waypoint(32'd0, 32'd0, 32'd0, 1, 0);
      send_waypoint(32'd22938, 32'd0, 32'h0001_0000, 0, 0);
      send_waypoint(32'd22938, 32'd0, 32'h0001_0000, 0, 0);
      send_waypoint(32'd22938, -32'sd13107, -32'sd65536, 0, 1);
      // restart mid path drops the open one
      send_waypoint(32'd5000, 32'd5000, 32'd0, 1, 0);
      send_waypoint(32'd9000, 32'd7000, 32'd10, 0, 0);
      send_waypoint(-32'sd7000, 32'd1, 32'd20, 1, 0);
      send_waypoint(-32'sd20000, 32'd1, -32'sd20, 0, 1);
      // no open path: acts as a start
      send_waypoint(32'd1000, 32'd1000, 32'd1000, 0, 0);
      send_waypoint(32'd1000, 32'd14000, 32'd2000, 0, 1);
      // full-range extremes cut by the sample cap, then a segment one LSB long
      send_waypoint(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
      send_waypoint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1);
      send_waypoint(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1, 0);
      send_waypoint(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1);

      random_phase(50, 1);

      write_step(23'h7F_FFFF);
      send_waypoint(32'd0, 32'd0, 32'd0, 1, 0);
      send_waypoint(32'h0200_0000, 32'd0, 32'd65536, 0, 1);
      random_phase(30, 0);

      write_step(23'd0);
      random_phase(30, 0);

      write_step(23'd1);
      random_phase(30, 0);

      write_step(23'd4194304);
      random_phase(30, 0);

      write_step(23'($urandom_range(100, 200000)));
      random_phase(30, 0);

      @(negedge clock);
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
